// ===== rtl/ppwm_pkg.sv =====
package ppwm_pkg;

  localparam int unsigned DEPTH        = 1024;
  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int unsigned TIME_WIDTH   = 32;

  localparam int unsigned PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_WIDTH = $clog2(DEPTH + 1);

  localparam int unsigned THR_WIDTH       = 16;
  localparam int unsigned TIMEOUT_WIDTH   = 32;
  localparam int unsigned TAP_WIDTH       = 10;
  localparam int unsigned CFG_INDEX_WIDTH = 2;
  localparam int unsigned CFG_DATA_WIDTH  = 32;
  localparam int unsigned CMP_WIDTH = ((TAP_WIDTH > CNT_WIDTH) ? TAP_WIDTH : CNT_WIDTH) + 1;

  localparam logic signed [THR_WIDTH-1:0]   THRESHOLD_RESET = '0;
  localparam logic [TIMEOUT_WIDTH-1:0]      TIMEOUT_RESET   = TIMEOUT_WIDTH'(10000);
  localparam logic [TAP_WIDTH-1:0]          TAP_RESET       = '0;

  // sum of nine samples, then divide by nine via reciprocal multiply
  localparam int unsigned SUM_WIDTH  = SAMPLE_WIDTH + 4;
  localparam int unsigned MEAN_SHIFT = SUM_WIDTH + 3;
  localparam logic [SUM_WIDTH-1:0] MEAN_MULT =
    SUM_WIDTH'(((64'd1 << MEAN_SHIFT) + 64'd8) / 64'd9);

  // timestamp mod 10000 == 0 split as 16 * 625
  localparam int unsigned GRID_LOW_BITS = 4;
  localparam int unsigned GRID_ODD      = 625;
  localparam int unsigned GRID_A_WIDTH  = TIME_WIDTH - GRID_LOW_BITS;
  localparam int unsigned GRID_SHIFT    = GRID_A_WIDTH + 10;
  localparam int unsigned GRID_M_WIDTH  = GRID_A_WIDTH + 1;
  localparam int unsigned GRID_Q_WIDTH  = GRID_A_WIDTH - 9;
  localparam logic [GRID_M_WIDTH-1:0] GRID_MULT =
    GRID_M_WIDTH'(((64'd1 << GRID_SHIFT) + 64'(GRID_ODD - 1)) / 64'(GRID_ODD));

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_TIMEOUT   = 2'd1,
    CFG_TAP       = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_nw;
    logic signed [SAMPLE_WIDTH-1:0] sample_n;
    logic signed [SAMPLE_WIDTH-1:0] sample_ne;
    logic signed [SAMPLE_WIDTH-1:0] sample_w;
    logic signed [SAMPLE_WIDTH-1:0] sample_c;
    logic signed [SAMPLE_WIDTH-1:0] sample_e;
    logic signed [SAMPLE_WIDTH-1:0] sample_sw;
    logic signed [SAMPLE_WIDTH-1:0] sample_s;
    logic signed [SAMPLE_WIDTH-1:0] sample_se;
    logic [TIME_WIDTH-1:0]          timestamp;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] window_mean;
    logic signed [SAMPLE_WIDTH-1:0] delayed_sample;
    logic                           rise;
    logic [TIME_WIDTH-1:0]          period;
    logic                           fall;
    logic [TIME_WIDTH-1:0]          pulse_width;
    logic                           dead;
  } out_item_t;

  typedef struct packed {
    logic                           valid;
    logic signed [SAMPLE_WIDTH-1:0] mean;
    logic                           above;
    logic                           below;
    logic [TIME_WIDTH-1:0]          ts;
    logic                           on_grid;
  } mean_res_t;

  typedef struct packed {
    logic                  rise;
    logic [TIME_WIDTH-1:0] period;
    logic                  fall;
    logic [TIME_WIDTH-1:0] pulse_width;
    logic                  dead;
  } det_res_t;

endpackage

// ===== rtl/pulse_period_width_monitor_top.sv =====
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_ready_o   | in_data_i  (in_item_t)
// out     | output    | out_valid_o / out_ready_i | out_data_o (out_item_t)
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One beat per cycle sustained while the output does not stall; each result is
// presented after its input beat is taken, through three register stages (sum,
// divide-by-nine multiply, history RAM read with the output register).
// History RAM has one write and one read port; a fill count stands in for its
// zero reset, so no clearing pass is needed and the block is ready after reset.
// A stalled output freezes the whole pipeline; cfg_ready_o is always high.
module pulse_period_width_monitor_top (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  ppwm_pkg::in_item_t                      in_data_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output ppwm_pkg::out_item_t                     out_data_o,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [ppwm_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index_i,
  input  logic [ppwm_pkg::CFG_DATA_WIDTH-1:0]     cfg_data_i
);

  localparam int unsigned PW = ppwm_pkg::PTR_WIDTH;
  localparam int unsigned CW = ppwm_pkg::CNT_WIDTH;
  localparam int unsigned MW = ppwm_pkg::CMP_WIDTH;

  logic signed [ppwm_pkg::THR_WIDTH-1:0] threshold_q;
  logic [ppwm_pkg::TIMEOUT_WIDTH-1:0]    timeout_q;
  logic [ppwm_pkg::TAP_WIDTH-1:0]        tap_q;

  logic adv;
  logic acc;
  ppwm_pkg::mean_res_t mres;
  ppwm_pkg::det_res_t  det;

  logic [PW-1:0] wr_ptr_q;
  logic [CW-1:0] fill_q;
  logic [PW-1:0] wptr_nxt;
  logic [CW-1:0] fill_nxt;
  logic [PW-1:0] tap_c;
  logic [PW-1:0] raddr;
  logic          push;

  logic                                   out_valid_q;
  ppwm_pkg::out_item_t                    out_q;
  logic                                   fwd_q;
  logic                                   hit_q;
  logic [ppwm_pkg::SAMPLE_WIDTH-1:0]      ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ppwm_pkg::THRESHOLD_RESET;
      timeout_q   <= ppwm_pkg::TIMEOUT_RESET;
      tap_q       <= ppwm_pkg::TAP_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ppwm_pkg::CFG_THRESHOLD: threshold_q <= cfg_data_i[ppwm_pkg::THR_WIDTH-1:0];
        ppwm_pkg::CFG_TIMEOUT:   timeout_q   <= cfg_data_i[ppwm_pkg::TIMEOUT_WIDTH-1:0];
        ppwm_pkg::CFG_TAP:       tap_q       <= cfg_data_i[ppwm_pkg::TAP_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign acc        = in_valid_i && adv;

  ppwm_mean u_mean (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .acc_i       (acc),
    .in_data_i   (in_data_i),
    .threshold_i (threshold_q),
    .res_o       (mres)
  );

  ppwm_detect u_detect (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .mres_i    (mres),
    .timeout_i (timeout_q),
    .det_o     (det)
  );

  always_comb begin
    push     = adv && mres.valid;
    wptr_nxt = (wr_ptr_q == PW'(ppwm_pkg::DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    fill_nxt = (fill_q == CW'(ppwm_pkg::DEPTH)) ? fill_q : fill_q + 1'b1;
    if (MW'(tap_q) > MW'(ppwm_pkg::DEPTH - 1)) begin
      tap_c = PW'(ppwm_pkg::DEPTH - 1);
    end else begin
      tap_c = PW'(tap_q);
    end
    if (wptr_nxt >= tap_c) begin
      raddr = wptr_nxt - tap_c;
    end else begin
      raddr = PW'((PW+1)'(wptr_nxt) + (PW+1)'(ppwm_pkg::DEPTH) - (PW+1)'(tap_c));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      fill_q   <= '0;
    end else if (push) begin
      wr_ptr_q <= wptr_nxt;
      fill_q   <= fill_nxt;
    end
  end

  ppwm_ram #(
    .WIDTH (ppwm_pkg::SAMPLE_WIDTH),
    .DEPTH (ppwm_pkg::DEPTH)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (wptr_nxt),
    .wdata_i (mres.mean),
    .re_i    (push),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= mres.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.window_mean    <= mres.mean;
      out_q.delayed_sample <= mres.mean;
      out_q.rise           <= det.rise;
      out_q.period         <= det.period;
      out_q.fall           <= det.fall;
      out_q.pulse_width    <= det.pulse_width;
      out_q.dead           <= det.dead;
      fwd_q                <= (tap_c == '0);
      hit_q                <= MW'(tap_c) < MW'(fill_nxt);
    end
  end

  always_comb begin
    out_data_o = out_q;
    if (!fwd_q) begin
      out_data_o.delayed_sample = hit_q ? ram_rdata : '0;
    end
  end

  assign out_valid_o = out_valid_q;

  a_rise_fall_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.rise && out_data_o.fall))
    else $error("rise and fall in one beat");

  a_dead_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.rise || out_data_o.fall)) |-> !out_data_o.dead)
    else $error("dead flagged on an edge beat");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    MW'(fill_q) <= MW'(ppwm_pkg::DEPTH))
    else $error("history fill count overflow");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(fill_q) && $stable(wr_ptr_q)))
    else $error("pipeline advanced under stall");

endmodule

// ===== rtl/ppwm_ram.sv =====
module ppwm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ppwm_mean.sv =====
module ppwm_mean (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   adv_i,
  input  logic                                   acc_i,
  input  ppwm_pkg::in_item_t                     in_data_i,
  input  logic signed [ppwm_pkg::THR_WIDTH-1:0]  threshold_i,
  output ppwm_pkg::mean_res_t                    res_o
);

  localparam int unsigned SW  = ppwm_pkg::SUM_WIDTH;
  localparam int unsigned GAW = ppwm_pkg::GRID_A_WIDTH;
  localparam int unsigned GPW = ppwm_pkg::GRID_A_WIDTH + ppwm_pkg::GRID_M_WIDTH;

  logic signed [SW-1:0] sum_d;
  logic                 s1_valid_q;
  logic signed [SW-1:0] s1_sum_q;
  logic [ppwm_pkg::TIME_WIDTH-1:0] s1_ts_q;

  logic                 neg_d;
  logic [SW-1:0]        mag_d;
  logic [2*SW-1:0]      prod_d;
  logic signed [SW-1:0] lim_d;
  logic [GPW-1:0]       gprod_d;

  logic                                   s2_valid_q;
  logic                                   s2_neg_q;
  logic [ppwm_pkg::SAMPLE_WIDTH-1:0]      s2_qmag_q;
  logic                                   s2_above_q;
  logic                                   s2_below_q;
  logic [ppwm_pkg::TIME_WIDTH-1:0]        s2_ts_q;
  logic [ppwm_pkg::GRID_Q_WIDTH-1:0]      s2_gq_q;

  assign sum_d = SW'(in_data_i.sample_nw) + SW'(in_data_i.sample_n) + SW'(in_data_i.sample_ne)
               + SW'(in_data_i.sample_w)  + SW'(in_data_i.sample_c) + SW'(in_data_i.sample_e)
               + SW'(in_data_i.sample_sw) + SW'(in_data_i.sample_s) + SW'(in_data_i.sample_se);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= acc_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_comb begin
    neg_d   = s1_sum_q[SW-1];
    mag_d   = neg_d ? SW'(-s1_sum_q) : SW'(s1_sum_q);
    prod_d  = (2*SW)'(mag_d) * (2*SW)'(ppwm_pkg::MEAN_MULT);
    lim_d   = (SW'(threshold_i) <<< 3) + SW'(threshold_i);
    gprod_d = GPW'(s1_ts_q[ppwm_pkg::TIME_WIDTH-1:ppwm_pkg::GRID_LOW_BITS])
            * GPW'(ppwm_pkg::GRID_MULT);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_sum_q   <= sum_d;
      s1_ts_q    <= in_data_i.timestamp;
      s2_neg_q   <= neg_d;
      s2_qmag_q  <= prod_d[ppwm_pkg::MEAN_SHIFT +: ppwm_pkg::SAMPLE_WIDTH];
      s2_above_q <= s1_sum_q > lim_d;
      s2_below_q <= s1_sum_q < lim_d;
      s2_ts_q    <= s1_ts_q;
      s2_gq_q    <= gprod_d[ppwm_pkg::GRID_SHIFT +: ppwm_pkg::GRID_Q_WIDTH];
    end
  end

  always_comb begin
    res_o.valid   = s2_valid_q;
    res_o.mean    = s2_neg_q ? -s2_qmag_q : s2_qmag_q;
    res_o.above   = s2_above_q;
    res_o.below   = s2_below_q;
    res_o.ts      = s2_ts_q;
    res_o.on_grid = (s2_ts_q[ppwm_pkg::GRID_LOW_BITS-1:0] == '0)
                 && (((GAW+1)'(s2_gq_q) * (GAW+1)'(ppwm_pkg::GRID_ODD))
                     == (GAW+1)'(s2_ts_q[ppwm_pkg::TIME_WIDTH-1:ppwm_pkg::GRID_LOW_BITS]));
  end

endmodule

// ===== rtl/ppwm_detect.sv =====
module ppwm_detect (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  adv_i,
  input  ppwm_pkg::mean_res_t                   mres_i,
  input  logic [ppwm_pkg::TIMEOUT_WIDTH-1:0]    timeout_i,
  output ppwm_pkg::det_res_t                    det_o
);

  logic                            in_pulse_q;
  logic [ppwm_pkg::TIME_WIDTH-1:0] last_rise_q;
  logic [ppwm_pkg::TIME_WIDTH-1:0] last_fall_q;
  logic [ppwm_pkg::TIME_WIDTH-1:0] since_rise;
  logic [ppwm_pkg::TIME_WIDTH-1:0] since_fall;

  always_comb begin
    since_rise        = mres_i.ts - last_rise_q;
    since_fall        = mres_i.ts - last_fall_q;
    det_o.rise        = mres_i.valid && !in_pulse_q && mres_i.above;
    det_o.fall        = mres_i.valid && in_pulse_q && mres_i.below;
    det_o.dead        = mres_i.valid && !in_pulse_q && !mres_i.above && !mres_i.on_grid
                     && (since_fall > timeout_i);
    det_o.period      = det_o.rise ? since_rise : '0;
    det_o.pulse_width = det_o.fall ? since_rise : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pulse_q  <= 1'b0;
      last_rise_q <= '0;
      last_fall_q <= '0;
    end else if (adv_i) begin
      if (det_o.rise) begin
        in_pulse_q  <= 1'b1;
        last_rise_q <= mres_i.ts;
      end
      if (det_o.fall) begin
        in_pulse_q  <= 1'b0;
        last_fall_q <= mres_i.ts;
      end
    end
  end

endmodule
